// File: design/jpsm_pkg.sv
// Package for the jog platter slip model: widths, constants, codes and shared types.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing else.
package jpsm_pkg;

  // Field and datapath widths.
  localparam int POS_W    = 48;
  localparam int EXT_W    = 66;
  localparam int RATE_W   = 20;
  localparam int PITCH_W  = 19;
  localparam int CNT_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int JOG_W    = 16;
  localparam int MA_W     = 17;
  localparam int MB_W     = 25;
  localparam int PROD_W   = 42;
  localparam int DVD_W    = 35;
  localparam int STEP_W   = 6;
  localparam int CIDX_W   = 8;
  localparam int CDAT_W   = 32;

  // Samples per tick as a shift (256 samples per buffer).
  localparam int BUF_SHIFT = 8;

  // Sequencer lengths.
  localparam int DIV_STEPS = 35;
  localparam int PP_STEPS  = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic signed [POS_W-1:0] POS_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN     = 48'sh8000_0000_0000;
  localparam logic signed [POS_W-1:0] SETTLE_BAND = 48'sd655360;
  localparam logic signed [POS_W-1:0] STOP_BAND   = 48'sd66;
  localparam logic signed [PROD_W-1:0] SCRATCH_LIM = 42'sd91750400;
  localparam logic signed [RATE_W-1:0] RATE_MAX   = 20'sh7FFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN   = 20'sh80000;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] CFG_PITCH    = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_SPIN_UP  = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_SPIN_DN  = 8'd2;
  localparam logic [CIDX_W-1:0] CFG_NUDGE    = 8'd3;
  localparam logic [CIDX_W-1:0] CFG_SCRATCH  = 8'd4;
  localparam logic [CIDX_W-1:0] CFG_SPRING   = 8'd5;
  localparam logic [CIDX_W-1:0] CFG_DAMP     = 8'd6;
  localparam logic [CIDX_W-1:0] CFG_DWELL    = 8'd7;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_PLAY  = 2'd1,
    KIND_JOG   = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MOT_IDLE = 2'd0,
    MOT_UP   = 2'd1,
    MOT_RUN  = 2'd2,
    MOT_DOWN = 2'd3
  } motor_e;

  typedef enum logic [1:0] {
    SLIP_LAM     = 2'd0,
    SLIP_SCRATCH = 2'd1,
    SLIP_NUDGE   = 2'd2,
    SLIP_TOLAM   = 2'd3
  } slip_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EVMUL,
    ST_EVENT,
    ST_MULR,
    ST_DIVLD,
    ST_DIV,
    ST_MOTFIN,
    ST_SLIP,
    ST_PP,
    ST_SPEED,
    ST_DISP,
    ST_ACT,
    ST_STOP,
    ST_FIN
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EVMUL,
    OP_EVENT,
    OP_MULR,
    OP_DIVLD,
    OP_DIV,
    OP_MOTFIN,
    OP_LAM,
    OP_TOLAM,
    OP_SHIFT,
    OP_PP,
    OP_SPEED,
    OP_DISP,
    OP_ACT,
    OP_STOP,
    OP_FIN
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_e               op;
    logic [STEP_W-1:0] idx;
    logic              take;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  is_tick;
    logic  need_div;
    slip_e slip_phase;
  } status_t;

  // Saturate a wide signed value to the 48-bit position range.
  function automatic logic signed [POS_W-1:0] sat48(input logic signed [EXT_W-1:0] x);
    logic signed [POS_W-1:0] r;
    if (x > EXT_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (x < EXT_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = x[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/jpsm_if.sv
// Channel interfaces of the jog platter slip model: event input, result output, config.
// Depends on jpsm_pkg for field widths.

interface jpsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [jpsm_pkg::JOG_W-1:0]   jog_delta;
  logic                                scratch_hold;
  modport source (output valid, kind, jog_delta, scratch_hold, input ready);
  modport sink   (input valid, kind, jog_delta, scratch_hold, output ready);
endinterface

interface jpsm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [jpsm_pkg::POS_W-1:0]   needle_head;
  logic signed [jpsm_pkg::RATE_W-1:0]  motor_rate;
  logic [1:0]                          motor_mode;
  logic [1:0]                          slip_mode;
  logic                                safe_to_stop;
  modport source (output valid, needle_head, motor_rate, motor_mode, slip_mode,
                  safe_to_stop, input ready);
  modport sink   (input valid, needle_head, motor_rate, motor_mode, slip_mode,
                  safe_to_stop, output ready);
endinterface

interface jpsm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [jpsm_pkg::CIDX_W-1:0]         reg_index;
  logic [jpsm_pkg::CDAT_W-1:0]         reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// File: design/jpsm_ctrl.sv
// Controller of the jog platter slip model: sequences each transaction through the datapath.
// Depends on jpsm_pkg for the state, command and status types.
module jpsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  jpsm_pkg::status_t   status_i,
  output jpsm_pkg::cmd_t      cmd_o
);

  jpsm_pkg::ctrl_state_e state_q, state_d;
  logic [jpsm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic fin_go;

  // The result register is free when empty or being drained this cycle.
  assign fin_go = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jpsm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = jpsm_pkg::ST_DECODE;
      end
      jpsm_pkg::ST_DECODE: begin
        if (!status_i.is_tick) begin
          state_d = jpsm_pkg::ST_EVMUL;
        end else if (status_i.need_div) begin
          state_d = jpsm_pkg::ST_MULR;
        end else begin
          state_d = jpsm_pkg::ST_MOTFIN;
        end
      end
      jpsm_pkg::ST_EVMUL:  state_d = jpsm_pkg::ST_EVENT;
      jpsm_pkg::ST_EVENT:  state_d = jpsm_pkg::ST_FIN;
      jpsm_pkg::ST_MULR:   state_d = jpsm_pkg::ST_DIVLD;
      jpsm_pkg::ST_DIVLD:  state_d = jpsm_pkg::ST_DIV;
      jpsm_pkg::ST_DIV: begin
        if (cnt_q == jpsm_pkg::STEP_W'(jpsm_pkg::DIV_STEPS - 1)) state_d = jpsm_pkg::ST_MOTFIN;
      end
      jpsm_pkg::ST_MOTFIN: state_d = jpsm_pkg::ST_SLIP;
      jpsm_pkg::ST_SLIP: begin
        if (status_i.slip_phase == jpsm_pkg::SLIP_SCRATCH ||
            status_i.slip_phase == jpsm_pkg::SLIP_NUDGE) begin
          state_d = jpsm_pkg::ST_PP;
        end else begin
          state_d = jpsm_pkg::ST_STOP;
        end
      end
      jpsm_pkg::ST_PP: begin
        if (cnt_q == jpsm_pkg::STEP_W'(jpsm_pkg::PP_STEPS - 1)) state_d = jpsm_pkg::ST_SPEED;
      end
      jpsm_pkg::ST_SPEED:  state_d = jpsm_pkg::ST_DISP;
      jpsm_pkg::ST_DISP:   state_d = jpsm_pkg::ST_ACT;
      jpsm_pkg::ST_ACT:    state_d = jpsm_pkg::ST_STOP;
      jpsm_pkg::ST_STOP:   state_d = jpsm_pkg::ST_FIN;
      jpsm_pkg::ST_FIN: begin
        if (fin_go) state_d = jpsm_pkg::ST_IDLE;
      end
      default:             state_d = jpsm_pkg::ST_IDLE;
    endcase
  end

  // Outputs: command to the datapath and handshake signals.
  always_comb begin
    cmd_o.op   = jpsm_pkg::OP_NONE;
    cmd_o.idx  = cnt_q;
    cmd_o.take = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      jpsm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      jpsm_pkg::ST_DECODE: cmd_o.op = jpsm_pkg::OP_NONE;
      jpsm_pkg::ST_EVMUL:  cmd_o.op = jpsm_pkg::OP_EVMUL;
      jpsm_pkg::ST_EVENT:  cmd_o.op = jpsm_pkg::OP_EVENT;
      jpsm_pkg::ST_MULR:   cmd_o.op = jpsm_pkg::OP_MULR;
      jpsm_pkg::ST_DIVLD:  cmd_o.op = jpsm_pkg::OP_DIVLD;
      jpsm_pkg::ST_DIV:    cmd_o.op = jpsm_pkg::OP_DIV;
      jpsm_pkg::ST_MOTFIN: cmd_o.op = jpsm_pkg::OP_MOTFIN;
      jpsm_pkg::ST_SLIP: begin
        unique case (status_i.slip_phase)
          jpsm_pkg::SLIP_LAM:   cmd_o.op = jpsm_pkg::OP_LAM;
          jpsm_pkg::SLIP_TOLAM: cmd_o.op = jpsm_pkg::OP_TOLAM;
          default:              cmd_o.op = jpsm_pkg::OP_SHIFT;
        endcase
      end
      jpsm_pkg::ST_PP:     cmd_o.op = jpsm_pkg::OP_PP;
      jpsm_pkg::ST_SPEED:  cmd_o.op = jpsm_pkg::OP_SPEED;
      jpsm_pkg::ST_DISP:   cmd_o.op = jpsm_pkg::OP_DISP;
      jpsm_pkg::ST_ACT:    cmd_o.op = jpsm_pkg::OP_ACT;
      jpsm_pkg::ST_STOP:   cmd_o.op = jpsm_pkg::OP_STOP;
      jpsm_pkg::ST_FIN: begin
        if (fin_go) cmd_o.op = jpsm_pkg::OP_FIN;
      end
      default:             cmd_o.op = jpsm_pkg::OP_NONE;
    endcase
  end

  // Loop counter restarts whenever the state changes.
  assign cnt_d = (state_d != state_q) ? '0 : cnt_q + 1'b1;

  // The result stays valid until taken; a new one is loaded in the finish state.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == jpsm_pkg::ST_FIN && fin_go) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jpsm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/jpsm_dp.sv
// Datapath of the jog platter slip model: configuration, platter state, shared
// multiplier, serial divider and result register. Depends on jpsm_pkg.
module jpsm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  jpsm_pkg::cmd_t                        cmd_i,
  output jpsm_pkg::status_t                     status_o,
  input  logic                                  cfg_we_i,
  input  logic [jpsm_pkg::CIDX_W-1:0]           cfg_index_i,
  input  logic [jpsm_pkg::CDAT_W-1:0]           cfg_data_i,
  input  logic [1:0]                            kind_i,
  input  logic signed [jpsm_pkg::JOG_W-1:0]     jog_delta_i,
  input  logic                                  scratch_hold_i,
  output logic signed [jpsm_pkg::POS_W-1:0]     needle_head_o,
  output logic signed [jpsm_pkg::RATE_W-1:0]    motor_rate_o,
  output logic [1:0]                            motor_mode_o,
  output logic [1:0]                            slip_mode_o,
  output logic                                  safe_to_stop_o
);

  localparam int POS_W = jpsm_pkg::POS_W;
  localparam int EXT_W = jpsm_pkg::EXT_W;

  // Configuration registers.
  logic [jpsm_pkg::PITCH_W-1:0] pitch_q;
  logic [jpsm_pkg::CNT_W-1:0]   up_q, down_q, spring_q, damp_q, dwell_q;
  logic [jpsm_pkg::GAIN_W-1:0]  nudge_q, scratch_q;

  // Latched transaction.
  jpsm_pkg::kind_e                   kind_q;
  logic signed [jpsm_pkg::JOG_W-1:0] delta_q;
  logic                              hold_q;

  // Platter state.
  logic                               on_q, spool_q, done_q;
  jpsm_pkg::motor_e                   mphase_q;
  jpsm_pkg::slip_e                    sphase_q;
  logic [jpsm_pkg::CNT_W-1:0]         ramp_q, settle_q;
  logic [jpsm_pkg::PITCH_W-1:0]       drive_q;
  logic signed [jpsm_pkg::RATE_W-1:0] live_q;
  logic signed [POS_W-1:0]            target_q, actual_q, shift_q, speed_q, d_q;

  // Arithmetic working registers.
  logic signed [EXT_W-1:0]            acc_s_q, acc_c_q;
  logic signed [jpsm_pkg::PROD_W-1:0] prod_q;
  logic [jpsm_pkg::DVD_W-1:0]         dvd_q;
  logic [jpsm_pkg::CNT_W-1:0]         rem_q;
  logic                               neg_q;

  logic signed [jpsm_pkg::MA_W-1:0]   mul_a;
  logic signed [jpsm_pkg::MB_W-1:0]   mul_b;
  logic                               nudge_sel;
  logic [jpsm_pkg::STEP_W-1:0]        pidx;

  assign nudge_sel = (mphase_q == jpsm_pkg::MOT_RUN) && !hold_q;

  assign status_o.is_tick    = (kind_q == jpsm_pkg::KIND_TICK);
  assign status_o.need_div   = (mphase_q == jpsm_pkg::MOT_UP && up_q != '0) ||
                               (mphase_q == jpsm_pkg::MOT_DOWN && down_q != '0);
  assign status_o.slip_phase = sphase_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q   <= 19'd65536;
      up_q      <= 16'd16;
      down_q    <= 16'd16;
      nudge_q   <= 24'd65536;
      scratch_q <= 24'd65536;
      spring_q  <= 16'd4096;
      damp_q    <= 16'd16384;
      dwell_q   <= 16'd32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jpsm_pkg::CFG_PITCH:   pitch_q   <= cfg_data_i[jpsm_pkg::PITCH_W-1:0];
        jpsm_pkg::CFG_SPIN_UP: up_q      <= cfg_data_i[jpsm_pkg::CNT_W-1:0];
        jpsm_pkg::CFG_SPIN_DN: down_q    <= cfg_data_i[jpsm_pkg::CNT_W-1:0];
        jpsm_pkg::CFG_NUDGE:   nudge_q   <= cfg_data_i[jpsm_pkg::GAIN_W-1:0];
        jpsm_pkg::CFG_SCRATCH: scratch_q <= cfg_data_i[jpsm_pkg::GAIN_W-1:0];
        jpsm_pkg::CFG_SPRING:  spring_q  <= cfg_data_i[jpsm_pkg::CNT_W-1:0];
        jpsm_pkg::CFG_DAMP:    damp_q    <= cfg_data_i[jpsm_pkg::CNT_W-1:0];
        jpsm_pkg::CFG_DWELL:   dwell_q   <= cfg_data_i[jpsm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the transaction when it is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= jpsm_pkg::KIND_TICK;
    end else if (cmd_i.take) begin
      kind_q <= jpsm_pkg::kind_e'(kind_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      delta_q <= jog_delta_i;
      hold_q  <= scratch_hold_i;
    end
  end

  // Shared multiplier operand selection: jog gain, ramp product, spring and damping chunks.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      jpsm_pkg::OP_EVMUL: begin
        mul_a = jpsm_pkg::MA_W'(delta_q);
        mul_b = $signed({1'b0, nudge_sel ? nudge_q : scratch_q});
      end
      jpsm_pkg::OP_MULR: begin
        if (mphase_q == jpsm_pkg::MOT_UP) begin
          mul_a = $signed({1'b0, ramp_q});
          mul_b = $signed(jpsm_pkg::MB_W'(pitch_q));
        end else begin
          mul_a = $signed({1'b0, down_q}) - $signed({1'b0, ramp_q});
          mul_b = $signed(jpsm_pkg::MB_W'(drive_q));
        end
      end
      jpsm_pkg::OP_PP: begin
        case (cmd_i.idx)
          6'd0: mul_a = $signed({1'b0, d_q[15:0]});
          6'd1: mul_a = $signed({1'b0, d_q[31:16]});
          6'd2: mul_a = $signed({d_q[47], d_q[47:32]});
          6'd3: mul_a = $signed({1'b0, speed_q[15:0]});
          6'd4: mul_a = $signed({1'b0, speed_q[31:16]});
          6'd5: mul_a = $signed({speed_q[47], speed_q[47:32]});
          default: mul_a = '0;
        endcase
        mul_b = (cmd_i.idx < 6'd3) ? $signed(jpsm_pkg::MB_W'(spring_q))
                                   : $signed(jpsm_pkg::MB_W'(damp_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Partial product placement: the product registered last cycle belongs to step idx-1.
  logic signed [EXT_W-1:0] pp_term;
  always_comb begin
    pidx = cmd_i.idx - 1'b1;
    case (pidx)
      6'd1, 6'd4: pp_term = EXT_W'(prod_q) <<< 16;
      6'd2, 6'd5: pp_term = EXT_W'(prod_q) <<< 32;
      default:    pp_term = EXT_W'(prod_q);
    endcase
  end

  // Serial restoring divider step.
  logic [jpsm_pkg::CNT_W:0]   rem_t;
  logic [jpsm_pkg::CNT_W-1:0] divisor;
  logic                       rem_ge;
  assign divisor = (mphase_q == jpsm_pkg::MOT_UP) ? up_q : down_q;
  assign rem_t   = {rem_q, dvd_q[jpsm_pkg::DVD_W-1]};
  assign rem_ge  = rem_t >= {1'b0, divisor};

  // Quotient with sign restored and saturated to the rate range.
  logic signed [jpsm_pkg::RATE_W-1:0] live_div;
  always_comb begin
    if (!neg_q) begin
      live_div = (dvd_q > jpsm_pkg::DVD_W'(524287)) ? jpsm_pkg::RATE_MAX
                                                     : $signed(dvd_q[jpsm_pkg::RATE_W-1:0]);
    end else begin
      live_div = (dvd_q > jpsm_pkg::DVD_W'(524288)) ? jpsm_pkg::RATE_MIN
                                                     : $signed(-dvd_q[jpsm_pkg::RATE_W-1:0]);
    end
  end

  // Slip arithmetic.
  logic [jpsm_pkg::CNT_W-1:0] ramp_inc;
  logic signed [EXT_W-1:0]    factor, neg_s, neg_c, speed_sum;
  logic signed [POS_W-1:0]    lam_target, jog_target, d_new, actual_new;
  logic signed [jpsm_pkg::PROD_W-1:0] scr_clamped;
  logic [jpsm_pkg::CNT_W-1:0] settle_base;
  logic                       d_out;

  assign ramp_inc   = (ramp_q != jpsm_pkg::CNT_MAX) ? ramp_q + 1'b1 : ramp_q;
  assign factor     = EXT_W'(live_q) <<< jpsm_pkg::BUF_SHIFT;
  assign lam_target = jpsm_pkg::sat48(EXT_W'(target_q) + factor);
  assign neg_s      = -acc_s_q;
  assign neg_c      = -acc_c_q;
  assign speed_sum  = EXT_W'(speed_q) + (neg_s >>> 16) + (neg_c >>> 16);
  assign d_new      = jpsm_pkg::sat48(EXT_W'(d_q) + EXT_W'(speed_q));
  assign actual_new = jpsm_pkg::sat48(EXT_W'(target_q) - EXT_W'(d_q));
  assign d_out      = (d_q > jpsm_pkg::SETTLE_BAND) || (d_q < -jpsm_pkg::SETTLE_BAND);
  assign settle_base = d_out ? '0 : settle_q;

  always_comb begin
    scr_clamped = prod_q;
    if (prod_q > jpsm_pkg::SCRATCH_LIM) scr_clamped = jpsm_pkg::SCRATCH_LIM;
    if (prod_q < -jpsm_pkg::SCRATCH_LIM) scr_clamped = -jpsm_pkg::SCRATCH_LIM;
  end
  assign jog_target = jpsm_pkg::sat48(EXT_W'(target_q) +
                      EXT_W'(nudge_sel ? prod_q : scr_clamped));

  // Control state of the platter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= 1'b0;
      spool_q  <= 1'b0;
      done_q   <= 1'b0;
      mphase_q <= jpsm_pkg::MOT_IDLE;
      sphase_q <= jpsm_pkg::SLIP_LAM;
      ramp_q   <= '0;
      settle_q <= '0;
      drive_q  <= '0;
      live_q   <= '0;
      target_q <= '0;
      actual_q <= '0;
      shift_q  <= '0;
      speed_q  <= '0;
    end else begin
      case (cmd_i.op)
        jpsm_pkg::OP_EVENT: begin
          if (!spool_q) begin
            case (kind_q)
              jpsm_pkg::KIND_PLAY: begin
                ramp_q <= '0;
                if (!on_q) begin
                  on_q     <= 1'b1;
                  drive_q  <= pitch_q;
                  mphase_q <= jpsm_pkg::MOT_UP;
                end else begin
                  on_q     <= 1'b0;
                  mphase_q <= jpsm_pkg::MOT_DOWN;
                  sphase_q <= jpsm_pkg::SLIP_LAM;
                end
              end
              jpsm_pkg::KIND_JOG: begin
                target_q <= jog_target;
                sphase_q <= nudge_sel ? jpsm_pkg::SLIP_NUDGE : jpsm_pkg::SLIP_SCRATCH;
                settle_q <= '0;
              end
              jpsm_pkg::KIND_STOP: begin
                spool_q <= 1'b1;
                if (on_q) begin
                  done_q   <= 1'b0;
                  on_q     <= 1'b0;
                  mphase_q <= jpsm_pkg::MOT_DOWN;
                  ramp_q   <= '0;
                  sphase_q <= jpsm_pkg::SLIP_LAM;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        jpsm_pkg::OP_MOTFIN: begin
          case (mphase_q)
            jpsm_pkg::MOT_IDLE: live_q <= '0;
            jpsm_pkg::MOT_UP: begin
              if (up_q != '0) begin
                drive_q <= pitch_q;
                live_q  <= live_div;
                ramp_q  <= ramp_inc;
                if (ramp_inc >= up_q) mphase_q <= jpsm_pkg::MOT_RUN;
              end else begin
                live_q   <= jpsm_pkg::RATE_W'(drive_q);
                mphase_q <= jpsm_pkg::MOT_RUN;
              end
            end
            jpsm_pkg::MOT_RUN: begin
              drive_q <= pitch_q;
              live_q  <= jpsm_pkg::RATE_W'(pitch_q);
            end
            default: begin
              if (down_q != '0) begin
                live_q <= live_div;
                ramp_q <= ramp_inc;
                if (ramp_inc >= down_q) begin
                  drive_q  <= '0;
                  mphase_q <= jpsm_pkg::MOT_IDLE;
                end
              end else begin
                live_q   <= jpsm_pkg::RATE_W'(drive_q);
                drive_q  <= '0;
                mphase_q <= jpsm_pkg::MOT_IDLE;
              end
            end
          endcase
        end
        jpsm_pkg::OP_LAM: begin
          target_q <= lam_target;
          actual_q <= lam_target;
        end
        jpsm_pkg::OP_TOLAM: sphase_q <= jpsm_pkg::SLIP_LAM;
        jpsm_pkg::OP_SHIFT: shift_q <= jpsm_pkg::sat48(EXT_W'(shift_q) + factor);
        jpsm_pkg::OP_SPEED: speed_q <= jpsm_pkg::sat48(speed_sum);
        jpsm_pkg::OP_ACT: begin
          actual_q <= actual_new;
          if (settle_base > dwell_q) sphase_q <= jpsm_pkg::SLIP_TOLAM;
          settle_q <= (settle_base != jpsm_pkg::CNT_MAX) ? settle_base + 1'b1 : settle_base;
        end
        jpsm_pkg::OP_STOP: begin
          if (spool_q && actual_q < jpsm_pkg::STOP_BAND) done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers of the spring step and the divider.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      jpsm_pkg::OP_SHIFT: begin
        d_q     <= jpsm_pkg::sat48(EXT_W'(target_q) - EXT_W'(actual_q));
        acc_s_q <= '0;
        acc_c_q <= '0;
      end
      jpsm_pkg::OP_PP: begin
        if (cmd_i.idx != '0) begin
          if (pidx < 6'd3) acc_s_q <= acc_s_q + pp_term;
          else             acc_c_q <= acc_c_q + pp_term;
        end
      end
      jpsm_pkg::OP_DISP: d_q <= d_new;
      jpsm_pkg::OP_DIVLD: begin
        neg_q <= prod_q[jpsm_pkg::PROD_W-1];
        dvd_q <= prod_q[jpsm_pkg::PROD_W-1] ? jpsm_pkg::DVD_W'(-prod_q)
                                            : jpsm_pkg::DVD_W'(prod_q);
        rem_q <= '0;
      end
      jpsm_pkg::OP_DIV: begin
        rem_q <= rem_ge ? jpsm_pkg::CNT_W'(rem_t - {1'b0, divisor})
                        : rem_t[jpsm_pkg::CNT_W-1:0];
        dvd_q <= {dvd_q[jpsm_pkg::DVD_W-2:0], rem_ge};
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == jpsm_pkg::OP_FIN) begin
      needle_head_o  <= jpsm_pkg::sat48(EXT_W'(shift_q) + EXT_W'(actual_q));
      motor_rate_o   <= live_q;
      motor_mode_o   <= mphase_q;
      slip_mode_o    <= sphase_q;
      safe_to_stop_o <= done_q;
    end
  end

endmodule

// File: design/jog_platter_slip_model_core.sv
// Top level of the jog platter slip model: channels, controller and datapath.
// Depends on jpsm_pkg, the jpsm interfaces, jpsm_ctrl and jpsm_dp.
//
// Usage:
//   in_i carries one event per transaction: a tick, a play/pause toggle, a jog
//   delta or a transport stop. out_o returns exactly one result per event:
//   needle position, motor rate, motor mode, slip mode and the stop flag.
//   cfg_i writes the eight registers by index; it is always ready, and writes
//   to unknown indexes are dropped. Write it only while the block is idle.
// Sequencing and throughput:
//   Events other than ticks pass through decode, the jog gain product, the
//   event update and the finish step. A spin ramp adds the ramp product, the
//   divider load and a 35-step serial divider to a tick, and the spring step adds
//   a partial-product pass on the shared 17x25 multiplier, then the speed,
//   displacement and position updates. One event is in work at a time; the next
//   is accepted once the previous result sits in the output register.
// Reset:
//   Registers return to their defaults, the motor is idle, slip is laminar.
// Stalls:
//   A result is held in the output register until taken; the next event is
//   computed meanwhile and waits in the finish step until the register frees.
module jog_platter_slip_model_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  jpsm_in_if.sink           in_i,
  jpsm_out_if.source        out_o,
  jpsm_cfg_if.sink          cfg_i
);

  jpsm_pkg::cmd_t    cmd;
  jpsm_pkg::status_t status;

  // Configuration writes are taken every cycle.
  assign cfg_i.ready = 1'b1;

  jpsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  jpsm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.reg_index),
    .cfg_data_i     (cfg_i.reg_data),
    .kind_i         (in_i.kind),
    .jog_delta_i    (in_i.jog_delta),
    .scratch_hold_i (in_i.scratch_hold),
    .needle_head_o  (out_o.needle_head),
    .motor_rate_o   (out_o.motor_rate),
    .motor_mode_o   (out_o.motor_mode),
    .slip_mode_o    (out_o.slip_mode),
    .safe_to_stop_o (out_o.safe_to_stop)
  );

endmodule

// File: tb/sv/jog_platter_slip_model_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for jog_platter_slip_model_core: platter events are predicted
// by a local model of the motor ramp and slipmat spring and compared with every result.
// Depends on jpsm_pkg, the jpsm channel interfaces and the core itself.
module jog_platter_slip_model_core_tb;
  import jpsm_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    kind_e             kind;
    logic signed [15:0] delta;
    logic              hold;
  } platter_event_t;

  typedef struct {
    logic signed [POS_W-1:0]  needle;
    logic signed [RATE_W-1:0] rate;
    motor_e                   mmode;
    slip_e                    smode;
    logic                     stopped;
  } platter_result_t;

  logic clk_i;
  logic rst_ni;

  jpsm_in_if  in_if ();
  jpsm_out_if out_if ();
  jpsm_cfg_if cfg_if ();

  jog_platter_slip_model_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  platter_event_t  pending_events[$];
  platter_result_t expected_results[$];
  int              errors;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              in_taken;
  bit              hold_go;
  bit              hold_done;
  int              hold_left;
  int              cycles;

  // Register shadows of the local platter model.
  longint m_pitch, m_up_ticks, m_dn_ticks, m_nudge, m_scratch, m_spring, m_damp, m_dwell;
  // Platter state.
  bit     p_motor_on, p_spooling, p_stop_done;
  motor_e p_motor;
  slip_e  p_slip;
  longint p_ramp, p_settle;
  longint p_drive, p_live;
  longint p_target, p_actual, p_shift, p_speed;

  function automatic longint clamp_pos(input longint x);
    longint lim;
    lim = 64'sd140737488355327;
    if (x > lim) return lim;
    if (x < -lim - 1) return -lim - 1;
    return x;
  endfunction

  function automatic longint clamp_rate(input longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return x;
  endfunction

  // Advance the platter model by one event and return the result it produces.
  task automatic step_platter(input platter_event_t ev, output platter_result_t res);
    longint factor, d, accel, s;
    if (ev.kind == KIND_TICK) begin
      // Motor ramp.
      case (p_motor)
        MOT_IDLE: p_live = 0;
        MOT_UP: begin
          if (m_up_ticks != 0) begin
            p_drive = m_pitch;
            p_live  = clamp_rate(p_drive * p_ramp / m_up_ticks);
            if (p_ramp < 65535) p_ramp++;
          end else begin
            p_live = p_drive;
          end
          if (p_ramp >= m_up_ticks) p_motor = MOT_RUN;
        end
        MOT_RUN: begin
          p_drive = m_pitch;
          p_live  = p_drive;
        end
        default: begin
          if (m_dn_ticks != 0) begin
            p_live = clamp_rate(p_drive * (m_dn_ticks - p_ramp) / m_dn_ticks);
            if (p_ramp < 65535) p_ramp++;
          end else begin
            p_live = p_drive;
          end
          if (p_ramp >= m_dn_ticks) begin
            p_drive = 0;
            p_motor = MOT_IDLE;
          end
        end
      endcase
      // Slipmat spring, one Euler step.
      factor = p_live * 256;
      if (p_slip == SLIP_LAM) begin
        p_target = clamp_pos(p_target + factor);
        p_actual = p_target;
      end else if (p_slip == SLIP_SCRATCH || p_slip == SLIP_NUDGE) begin
        p_shift  = clamp_pos(p_shift + factor);
        d        = clamp_pos(p_target - p_actual);
        accel    = ((-(m_spring * d)) >>> 16) + ((-(m_damp * p_speed)) >>> 16);
        p_speed  = clamp_pos(p_speed + accel);
        d        = clamp_pos(d + p_speed);
        p_actual = clamp_pos(p_target - d);
        if (d > 655360 || d < -655360) p_settle = 0;
        if (p_settle > m_dwell) p_slip = SLIP_TOLAM;
        if (p_settle < 65535) p_settle++;
      end else begin
        p_slip = SLIP_LAM;
      end
      if (p_spooling && p_actual < 66) p_stop_done = 1;
    end else if (!p_spooling) begin
      case (ev.kind)
        KIND_PLAY: begin
          if (!p_motor_on) begin
            p_motor_on = 1;
            p_drive    = m_pitch;
            p_motor    = MOT_UP;
            p_ramp     = 0;
          end else begin
            p_motor_on = 0;
            p_motor    = MOT_DOWN;
            p_ramp     = 0;
            p_slip     = SLIP_LAM;
          end
        end
        KIND_JOG: begin
          if (p_motor == MOT_RUN && !ev.hold) begin
            p_target = clamp_pos(p_target + longint'(ev.delta) * m_nudge);
            p_slip   = SLIP_NUDGE;
          end else begin
            s = longint'(ev.delta) * m_scratch;
            if (s > 91750400) s = 91750400;
            if (s < -91750400) s = -91750400;
            p_target = clamp_pos(p_target + s);
            p_slip   = SLIP_SCRATCH;
          end
          p_settle = 0;
        end
        default: begin
          if (p_motor_on) begin
            p_stop_done = 0;
            p_motor_on  = 0;
            p_motor     = MOT_DOWN;
            p_ramp      = 0;
            p_slip      = SLIP_LAM;
          end else begin
            p_stop_done = 1;
          end
          p_spooling = 1;
        end
      endcase
    end
    res.needle  = POS_W'(clamp_pos(p_shift + p_actual));
    res.rate    = RATE_W'(p_live);
    res.mmode   = p_motor;
    res.smode   = p_slip;
    res.stopped = p_stop_done;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: presents queued events at the falling edge.
  always @(negedge clk_i) begin
    platter_event_t ev;
    if (!in_if.valid || in_taken) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = pending_events.pop_front();
        in_if.kind         <= ev.kind;
        in_if.jog_delta    <= ev.delta;
        in_if.scratch_hold <= ev.hold;
        in_if.valid        <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Accepted input transactions feed the predictor.
  always @(posedge clk_i) begin
    platter_event_t  ev;
    platter_result_t res;
    if (rst_ni && in_if.valid && in_if.ready) begin
      ev.kind  = kind_e'(in_if.kind);
      ev.delta = in_if.jog_delta;
      ev.hold  = in_if.scratch_hold;
      step_platter(ev, res);
      expected_results.push_back(res);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Monitor: each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    platter_result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, needle %0d", $time, out_if.needle_head);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_if.needle_head !== exp_r.needle) begin
          $display("%0t: needle_head expected %0d actual %0d", $time, exp_r.needle,
                   out_if.needle_head);
          errors++;
        end
        if (out_if.motor_rate !== exp_r.rate) begin
          $display("%0t: motor_rate expected %0d actual %0d", $time, exp_r.rate,
                   out_if.motor_rate);
          errors++;
        end
        if (out_if.motor_mode !== exp_r.mmode) begin
          $display("%0t: motor_mode expected %0d actual %0d", $time, exp_r.mmode,
                   out_if.motor_mode);
          errors++;
        end
        if (out_if.slip_mode !== exp_r.smode) begin
          $display("%0t: slip_mode expected %0d actual %0d", $time, exp_r.smode,
                   out_if.slip_mode);
          errors++;
        end
        if (out_if.safe_to_stop !== exp_r.stopped) begin
          $display("%0t: safe_to_stop expected %0d actual %0d", $time, exp_r.stopped,
                   out_if.safe_to_stop);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input longint data);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.reg_data  <= CDAT_W'(data);
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_PITCH:   m_pitch    = data & 64'h7FFFF;
      CFG_SPIN_UP: m_up_ticks = data & 64'hFFFF;
      CFG_SPIN_DN: m_dn_ticks = data & 64'hFFFF;
      CFG_NUDGE:   m_nudge    = data & 64'hFFFFFF;
      CFG_SCRATCH: m_scratch  = data & 64'hFFFFFF;
      CFG_SPRING:  m_spring   = data & 64'hFFFF;
      CFG_DAMP:    m_damp     = data & 64'hFFFF;
      CFG_DWELL:   m_dwell    = data & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input longint pitch, input longint up, input longint dn,
                           input longint nudge, input longint scratch, input longint spring,
                           input longint damp, input longint dwell);
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_SPIN_UP, up);
    write_reg(CFG_SPIN_DN, dn);
    write_reg(CFG_NUDGE, nudge);
    write_reg(CFG_SCRATCH, scratch);
    write_reg(CFG_SPRING, spring);
    write_reg(CFG_DAMP, damp);
    write_reg(CFG_DWELL, dwell);
  endtask

  task automatic push_event(input kind_e k, input logic signed [15:0] dj, input logic hold);
    platter_event_t ev;
    ev.kind  = k;
    ev.delta = dj;
    ev.hold  = hold;
    pending_events.push_back(ev);
  endtask

  // Random events; stops are allowed only when with_stop is set.
  task automatic push_random(input int count, input bit with_stop);
    int r;
    logic signed [15:0] dj;
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(99);
      dj = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(400)) - 200);
      if (with_stop && r < 2) push_event(KIND_STOP, dj, 1'($urandom));
      else if (r < 12) push_event(KIND_PLAY, dj, 1'($urandom));
      else if (r < 45) push_event(KIND_JOG, dj, 1'($urandom));
      else push_event(KIND_TICK, dj, 1'($urandom));
    end
  endtask

  // Wait until no event is queued, offered or in work.
  task automatic drain;
    wait (pending_events.size() == 0 && !in_if.valid && expected_results.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    errors        = 0;
    cycles        = 0;
    in_taken      = 0;
    hold_go       = 0;
    hold_done     = 0;
    hold_left     = 0;
    send_idle_pct = 33;
    recv_idle_pct = 69;
    m_pitch = 65536; m_up_ticks = 16; m_dn_ticks = 16; m_nudge = 65536;
    m_scratch = 65536; m_spring = 4096; m_damp = 16384; m_dwell = 32;
    p_motor_on = 0; p_spooling = 0; p_stop_done = 0;
    p_motor = MOT_IDLE; p_slip = SLIP_LAM; p_ramp = 0; p_settle = 0;
    p_drive = 0; p_live = 0; p_target = 0; p_actual = 0; p_shift = 0; p_speed = 0;
    in_if.valid = 0; in_if.kind = KIND_TICK; in_if.jog_delta = 0; in_if.scratch_hold = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.reg_index = 0; cfg_if.reg_data = 0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: short ramps, nudge, scratch clamp, extreme deltas, pause, unknown index.
    write_all(524287, 2, 3, 16777215, 16777215, 65535, 65535, 0);
    write_reg(8'd8, 32'hFFFF_FFFF);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_JOG, -16'sd1, 0);
    push_event(KIND_TICK, 0, 0);
    push_event(KIND_PLAY, 0, 0);
    repeat (3) push_event(KIND_TICK, 0, 0);
    push_event(KIND_JOG, 16'sd1, 0);
    repeat (2) push_event(KIND_TICK, 0, 0);
    push_event(KIND_JOG, 16'sh7FFF, 1);
    push_event(KIND_JOG, -16'sh8000, 1);
    push_event(KIND_JOG, -16'sh8000, 0);
    repeat (2) push_event(KIND_TICK, 0, 0);
    push_event(KIND_PLAY, 16'sh7FFF, 1);
    repeat (4) push_event(KIND_TICK, 0, 0);
    push_event(KIND_JOG, 0, 0);
    push_event(KIND_TICK, 0, 0);
    drain();

    // Random phases across register settings, extremes included.
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    push_random(250, 0);
    drain();
    write_all(524287, 65535, 65535, 16777215, 16777215, 65535, 65535, 65535);
    push_random(150, 0);
    drain();
    send_idle_pct = 69;
    recv_idle_pct = 33;
    write_all($urandom_range(524287), $urandom_range(20), $urandom_range(20),
              $urandom_range(16777215), $urandom_range(16777215), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(40));
    push_random(300, 0);
    drain();
    // Lower the ramps mid-flight to push the rate into saturation.
    write_all(524287, 1, 1, 65536, 65536, 4096, 16384, 32);
    push_random(150, 0);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(65536, 16, 16, 65536, 65536, 4096, 16384, 32);
    hold_go = 1;
    push_random(250, 0);
    drain();
    write_all($urandom_range(524287), $urandom_range(8), $urandom_range(8),
              $urandom_range(200000), $urandom_range(200000), $urandom_range(65535),
              $urandom_range(65535), $urandom_range(10));
    push_random(150, 1);
    repeat (40) push_event(KIND_TICK, 16'($urandom), 1'($urandom));

    wait (pending_events.size() == 0 && !in_if.valid && expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
